// ===== hdl/sha1bh_pkg.sv =====
`default_nettype none

package sha1bh_pkg;

    typedef struct packed {
        logic [31:0] word;
        logic        start;
        logic        blk_end;
        logic        emit;
    } t_entry;

    localparam logic [4:0][31:0] SHA_IV = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [3:0][31:0] ROUND_K = {
        32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
    };

    localparam logic [1:0] GRP_CH     = 2'd0;
    localparam logic [1:0] GRP_PAR_LO = 2'd1;
    localparam logic [1:0] GRP_MAJ    = 2'd2;
    localparam logic [1:0] GRP_LAST   = 2'd3;
    localparam logic [4:0] SUB_LAST   = 5'd19;
    localparam logic [2:0] DIGEST_LAST = 3'd4;
    localparam logic [3:0] POS_LAST   = 4'hf;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        rotl1 = {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        rotl5 = {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        rotl30 = {v[1:0], v[31:2]};
    endfunction

    function automatic logic [31:0] round_f(
        input logic [1:0]  grp,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        case (grp)
            GRP_CH:     round_f = (b & c) | (~b & d);
            GRP_PAR_LO: round_f = b ^ c ^ d;
            GRP_MAJ:    round_f = (b & c) | (b & d) | (c & d);
            default:    round_f = b ^ c ^ d;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1_block_hash.sv =====
`default_nettype none

// channel   ports                                        direction
// message   push, full, i_message_word/start/end         in
// digest    pop, empty, o_digest_word, o_digest_last     out
//
// a word passes the front combinationally into a small queue; the core takes
// one word a cycle while idle, and the 16th word of a block starts the 80
// rounds, followed by the chaining add, before the core takes words again
// a block that ends a message then delivers five digest words, one a cycle
// while pop keeps up; the input side keeps filling the queue meanwhile
// synchronous reset loads the initial chaining value and empties both sides

module sha1_block_hash #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_message_word,
    input  logic        i_message_start,
    input  logic        i_message_end,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    import sha1bh_pkg::*;

    t_entry w_wr_entry;
    t_entry w_rd_entry;
    logic   w_wr;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_q_pop;

    sha1bh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (i_message_word),
        .i_start  (i_message_start),
        .i_end    (i_message_end),
        .i_q_full (w_q_full),
        .o_full   (full),
        .o_wr     (w_wr),
        .o_entry  (w_wr_entry)
    );

    sha1bh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (w_wr_entry),
        .o_full  (w_q_full),
        .i_rd    (w_q_pop),
        .o_data  (w_rd_entry),
        .o_empty (w_q_empty)
    );

    sha1bh_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_entry     (w_rd_entry),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_digest_word (o_digest_word),
        .o_digest_last (o_digest_last)
    );

endmodule

`default_nettype wire

// ===== hdl/sha1bh_fifo.sv =====
`default_nettype none

module sha1bh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  sha1bh_pkg::t_entry  i_data,
    output logic                o_full,
    input  logic                i_rd,
    output sha1bh_pkg::t_entry  o_data,
    output logic                o_empty
);
    import sha1bh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          n_wr;
    logic          n_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign n_wr    = i_wr && !o_full;
    assign n_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_wr && !n_rd) begin
                r_count <= r_count + 1'b1;
            end else if (n_rd && !n_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sha1bh_front.sv =====
`default_nettype none

module sha1bh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [31:0]         i_word,
    input  logic                i_start,
    input  logic                i_end,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_wr,
    output sha1bh_pkg::t_entry  o_entry
);
    import sha1bh_pkg::*;

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       n_blk_end;

    assign n_pos     = i_start ? 4'd0 : r_pos;
    assign n_blk_end = (n_pos == POS_LAST);
    assign o_full    = i_q_full;
    assign o_wr      = i_push && !i_q_full;

    assign o_entry.word    = i_word;
    assign o_entry.start   = i_start;
    assign o_entry.blk_end = n_blk_end;
    assign o_entry.emit    = n_blk_end && i_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_wr) begin
            r_pos <= n_pos + 4'd1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sha1bh_core.sv =====
`default_nettype none

module sha1bh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  sha1bh_pkg::t_entry  i_q_entry,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [31:0]         o_digest_word,
    output logic                o_digest_last
);
    import sha1bh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [31:0] r_win [16];
    logic [31:0] r_chain [5];
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic [31:0] r_d;
    logic [31:0] r_e;
    logic [1:0]  r_grp;
    logic [4:0]  r_sub;
    logic        r_emit;
    logic [2:0]  r_k;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_last;

    logic [31:0] n_sched;
    logic [31:0] n_f;
    logic [31:0] n_temp;
    logic        n_out_free;

    assign o_q_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign n_sched       = rotl1(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]);
    assign n_f           = round_f(r_grp, r_b, r_c, r_d);
    assign n_temp        = rotl5(r_a) + n_f + r_e + r_win[0] + ROUND_K[r_grp];
    assign n_out_free    = !r_out_valid || i_pop;
    assign o_empty       = !r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_digest_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_grp       <= '0;
            r_sub       <= '0;
            r_k         <= '0;
            r_emit      <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= SHA_IV[i];
            end
        end else begin
            if (i_pop && r_out_valid && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        for (int i = 0; i < 15; i++) begin
                            r_win[i] <= r_win[i+1];
                        end
                        r_win[15] <= i_q_entry.word;
                        if (i_q_entry.start) begin
                            for (int i = 0; i < 5; i++) begin
                                r_chain[i] <= SHA_IV[i];
                            end
                        end
                        if (i_q_entry.blk_end) begin
                            r_a     <= i_q_entry.start ? SHA_IV[0] : r_chain[0];
                            r_b     <= i_q_entry.start ? SHA_IV[1] : r_chain[1];
                            r_c     <= i_q_entry.start ? SHA_IV[2] : r_chain[2];
                            r_d     <= i_q_entry.start ? SHA_IV[3] : r_chain[3];
                            r_e     <= i_q_entry.start ? SHA_IV[4] : r_chain[4];
                            r_emit  <= i_q_entry.emit;
                            r_grp   <= GRP_CH;
                            r_sub   <= '0;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    r_a <= n_temp;
                    r_b <= r_a;
                    r_c <= rotl30(r_b);
                    r_d <= r_c;
                    r_e <= r_d;
                    for (int i = 0; i < 15; i++) begin
                        r_win[i] <= r_win[i+1];
                    end
                    r_win[15] <= n_sched;
                    if (r_sub == SUB_LAST) begin
                        r_sub <= '0;
                        if (r_grp == GRP_LAST) begin
                            r_state <= S_ADD;
                        end else begin
                            r_grp <= r_grp + 2'd1;
                        end
                    end else begin
                        r_sub <= r_sub + 5'd1;
                    end
                end
                S_ADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    r_k        <= '0;
                    r_state    <= r_emit ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_chain[r_k];
                        r_out_last  <= (r_k == DIGEST_LAST);
                        if (r_k == DIGEST_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sha1bh_checker.sv =====
`default_nettype none

module sha1bh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [31:0] o_digest_word,
    input logic        o_digest_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("digest side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("message side full after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_digest_word) && $stable(o_digest_last)))
        else $error("waiting digest word changed");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_digest_last) |=> !empty)
        else $error("gap inside digest burst");

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_digest_last) |=> empty)
        else $error("digest word right after last one");

endmodule

bind sha1_block_hash sha1bh_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .pop           (pop),
    .empty         (empty),
    .o_digest_word (o_digest_word),
    .o_digest_last (o_digest_last)
);

`default_nettype wire
